### rtl/core/gzhl_pkg.sv
// Package for the gzip header locator: item types, phase and status codes, helpers.
`timescale 1ns / 1ps

package gzhl_pkg;

   // Width of the running byte counter and of the data start position.
   localparam int COUNT_BITS = 32;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic [7:0] MAGIC_ID1 = 8'h1F;
   localparam logic [7:0] MAGIC_ID2 = 8'h8B;

   // Flag byte bits as they appear in the header.
   localparam int FLG_HCRC_BIT    = 1;
   localparam int FLG_EXTRA_BIT   = 2;
   localparam int FLG_NAME_BIT    = 3;
   localparam int FLG_COMMENT_BIT = 4;

   // Bits of the stored flag nibble.
   localparam int HF_HCRC    = 0;
   localparam int HF_EXTRA   = 1;
   localparam int HF_NAME    = 2;
   localparam int HF_COMMENT = 3;

   localparam int FIXED_LEN   = 10;
   localparam int TRAILER_LEN = 8;
   localparam int HCRC_LEN    = 2;

   // Parser phases.
   localparam logic [3:0] PH_ID1     = 4'd0;
   localparam logic [3:0] PH_ID2     = 4'd1;
   localparam logic [3:0] PH_CM      = 4'd2;
   localparam logic [3:0] PH_FLG     = 4'd3;
   localparam logic [3:0] PH_FIXED   = 4'd4;
   localparam logic [3:0] PH_XLEN0   = 4'd5;
   localparam logic [3:0] PH_XLEN1   = 4'd6;
   localparam logic [3:0] PH_EXTRA   = 4'd7;
   localparam logic [3:0] PH_NAME    = 4'd8;
   localparam logic [3:0] PH_COMMENT = 4'd9;
   localparam logic [3:0] PH_HCRC    = 4'd10;
   localparam logic [3:0] PH_DATA    = 4'd11;
   localparam logic [3:0] PH_BAD     = 4'd12;

   // First optional section to look at when a section ends.
   localparam logic [2:0] STAGE_EXTRA   = 3'd0;
   localparam logic [2:0] STAGE_NAME    = 3'd1;
   localparam logic [2:0] STAGE_COMMENT = 3'd2;
   localparam logic [2:0] STAGE_HCRC    = 3'd3;
   localparam logic [2:0] STAGE_DATA    = 3'd4;

   // Result status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
   localparam logic [1:0] ST_TRUNC     = 2'd2;
   localparam logic [1:0] ST_SHORT     = 2'd3;

   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] deflate_offset;
      logic [31:0] deflate_length;
   } rsp_item_type;

   // Parser output toward the result register.
   typedef struct packed {
      logic         emit;
      rsp_item_type item;
   } parse_out_type;

   // Clamp a count to 32 bits.
   function automatic logic [31:0] sat32(input count_type v);
      logic [64:0] ext;
      ext = 65'(v);
      if (ext > 65'h0_FFFF_FFFF) begin
         return 32'hFFFF_FFFF;
      end
      return ext[31:0];
   endfunction

endpackage

### rtl/core/gzip_header_locator.sv
// Top level of the gzip header locator: input register, parser and result register.
`timescale 1ns / 1ps

// Usage:
//   The req_ channel carries one byte of a gzip file per transaction, with
//   first_byte marking the start of a file and last_byte its end. For each
//   transaction with last_byte set, one rsp_ transaction follows with the
//   status, the deflate data offset and the deflate data length.
//   A transaction is taken on a clock edge where valid is high and stall low.
//   A byte is registered at acceptance and parsed from the input register;
//   its result is loaded into the result register when the byte advances.
//   Throughput: one byte per cycle while req_stall is low, as the parser
//   updates its state between the input register and the result register.
//   When the receiver stalls with a result pending, a byte that would make
//   another result waits in the input register and req_stall rises; bytes
//   that make no result keep flowing into the parser meanwhile.
//   Reset (synchronous, active high) empties both registers and returns the
//   parser to expecting the first magic byte with all counts at zero.

module gzip_header_locator
   import gzhl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   logic          in_vld_ff, in_vld_in;
   req_item_type  in_item_ff;
   logic          advance;
   logic          accept;
   parse_out_type parse_out;
   parse_out_type rsp_load;

   // Hold the registered byte when its result has nowhere to go.
   assign advance   = in_vld_ff && !(parse_out.emit && rsp_valid && rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign in_vld_in = accept || (in_vld_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_data;
      end
   end

   gzhl_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (parse_out)
   );

   always_comb begin
      rsp_load      = parse_out;
      rsp_load.emit = parse_out.emit && advance;
   end

   gzhl_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_vld_ff && in_item_ff.last_byte && rsp_valid))
      else $error("input stalled without a blocked result");

   a_result_follows_last: assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.last_byte) |=> rsp_valid)
      else $error("last byte processed without a result");

   a_held_byte_stable: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !advance) |=> (in_vld_ff && $stable(in_item_ff)))
      else $error("held input byte changed");

endmodule

### rtl/core/gzhl_parse.sv
// Header parser: per-file state, next-state logic and result formation for one byte.
`timescale 1ns / 1ps

module gzhl_parse
   import gzhl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  req_item_type  item,
   output parse_out_type result
);

   logic [3:0]  phase_ff, phase_in;
   count_type   byte_count_ff, byte_count_in;
   logic [3:0]  flags_ff, flags_in;
   logic [15:0] skip_left_ff, skip_left_in;
   logic [7:0]  xlen_low_ff, xlen_low_in;
   count_type   data_start_ff, data_start_in;
   logic [1:0]  error_code_ff, error_code_in;

   logic [3:0]  ph_cur;
   count_type   bc_cur;
   logic [3:0]  fl_cur;
   logic [15:0] sk_cur;
   logic [7:0]  xl_cur;
   count_type   ds_cur;
   logic [1:0]  ec_cur;
   logic        enter;
   logic [2:0]  stage;
   count_type   span;
   logic [7:0]  b;

   assign b = item.data_byte;

   always_comb begin
      // Restart before taking the first byte of a file.
      if (item.first_byte) begin
         ph_cur = PH_ID1;
         bc_cur = '0;
         fl_cur = '0;
         sk_cur = '0;
         xl_cur = '0;
         ds_cur = '0;
         ec_cur = '0;
      end else begin
         ph_cur = phase_ff;
         bc_cur = byte_count_ff;
         fl_cur = flags_ff;
         sk_cur = skip_left_ff;
         xl_cur = xlen_low_ff;
         ds_cur = data_start_ff;
         ec_cur = error_code_ff;
      end

      byte_count_in = (bc_cur == COUNT_MAX) ? bc_cur : bc_cur + count_type'(1);
      phase_in      = ph_cur;
      flags_in      = fl_cur;
      skip_left_in  = sk_cur;
      xlen_low_in   = xl_cur;
      data_start_in = ds_cur;
      error_code_in = ec_cur;
      enter         = 1'b0;
      stage         = STAGE_EXTRA;

      case (ph_cur)
         PH_ID1: begin
            if (b != MAGIC_ID1) begin
               error_code_in = ST_BAD_MAGIC;
               phase_in      = PH_BAD;
            end else begin
               phase_in = PH_ID2;
            end
         end
         PH_ID2: begin
            if (b != MAGIC_ID2) begin
               error_code_in = ST_BAD_MAGIC;
               phase_in      = PH_BAD;
            end else begin
               phase_in = PH_CM;
            end
         end
         PH_CM: begin
            phase_in = PH_FLG;
         end
         PH_FLG: begin
            flags_in[HF_HCRC]    = b[FLG_HCRC_BIT];
            flags_in[HF_EXTRA]   = b[FLG_EXTRA_BIT];
            flags_in[HF_NAME]    = b[FLG_NAME_BIT];
            flags_in[HF_COMMENT] = b[FLG_COMMENT_BIT];
            skip_left_in         = 16'(FIXED_LEN - 4);
            phase_in             = PH_FIXED;
         end
         PH_FIXED: begin
            skip_left_in = sk_cur - 16'd1;
            if (skip_left_in == 16'd0) begin
               enter = 1'b1;
               stage = STAGE_EXTRA;
            end
         end
         PH_XLEN0: begin
            xlen_low_in = b;
            phase_in    = PH_XLEN1;
         end
         PH_XLEN1: begin
            skip_left_in = {b, xl_cur};
            if (skip_left_in == 16'd0) begin
               enter = 1'b1;
               stage = STAGE_NAME;
            end else begin
               phase_in = PH_EXTRA;
            end
         end
         PH_EXTRA: begin
            skip_left_in = sk_cur - 16'd1;
            if (skip_left_in == 16'd0) begin
               enter = 1'b1;
               stage = STAGE_NAME;
            end
         end
         PH_NAME: begin
            if (b == 8'd0) begin
               enter = 1'b1;
               stage = STAGE_COMMENT;
            end
         end
         PH_COMMENT: begin
            if (b == 8'd0) begin
               enter = 1'b1;
               stage = STAGE_HCRC;
            end
         end
         PH_HCRC: begin
            skip_left_in = sk_cur - 16'd1;
            if (skip_left_in == 16'd0) begin
               enter = 1'b1;
               stage = STAGE_DATA;
            end
         end
         default: begin
         end
      endcase

      // Advance to the first present section at or after the requested one.
      if (enter) begin
         if (stage <= STAGE_EXTRA && fl_cur[HF_EXTRA]) begin
            phase_in = PH_XLEN0;
         end else if (stage <= STAGE_NAME && flags_in[HF_NAME]) begin
            phase_in = PH_NAME;
         end else if (stage <= STAGE_COMMENT && flags_in[HF_COMMENT]) begin
            phase_in = PH_COMMENT;
         end else if (stage <= STAGE_HCRC && flags_in[HF_HCRC]) begin
            phase_in     = PH_HCRC;
            skip_left_in = 16'(HCRC_LEN);
         end else begin
            phase_in      = PH_DATA;
            data_start_in = byte_count_in;
         end
      end

      span = byte_count_in - data_start_in;

      result.emit = item.last_byte;
      result.item.deflate_offset = '0;
      result.item.deflate_length = '0;
      if (byte_count_in < count_type'(FIXED_LEN)) begin
         result.item.status = ST_TRUNC;
      end else if (error_code_in == ST_BAD_MAGIC) begin
         result.item.status = ST_BAD_MAGIC;
      end else if (phase_in != PH_DATA) begin
         result.item.status = ST_TRUNC;
      end else if (span < count_type'(TRAILER_LEN)) begin
         result.item.status = ST_SHORT;
      end else begin
         result.item.status         = ST_OK;
         result.item.deflate_offset = sat32(data_start_in);
         result.item.deflate_length = sat32(span - count_type'(TRAILER_LEN));
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.last_byte)) begin
         phase_ff      <= PH_ID1;
         byte_count_ff <= '0;
         flags_ff      <= '0;
         skip_left_ff  <= '0;
         xlen_low_ff   <= '0;
         data_start_ff <= '0;
         error_code_ff <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
         flags_ff      <= flags_in;
         skip_left_ff  <= skip_left_in;
         xlen_low_ff   <= xlen_low_in;
         data_start_ff <= data_start_in;
         error_code_ff <= error_code_in;
      end
   end

   a_err_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (result.emit && result.item.status != ST_OK) |->
         (result.item.deflate_offset == 32'd0 && result.item.deflate_length == 32'd0))
      else $error("error result carries nonzero offset or length");

   a_restart_after_result: assert property (@(posedge clock) disable iff (reset)
      (step && item.last_byte) |=> (phase_ff == PH_ID1 && byte_count_ff == '0))
      else $error("parser did not restart after a result");

   a_ok_offset_min: assert property (@(posedge clock) disable iff (reset)
      (result.emit && result.item.status == ST_OK) |->
         (result.item.deflate_offset >= 32'(FIXED_LEN)))
      else $error("ok result with offset inside fixed header");

endmodule

### rtl/core/gzhl_rsp_reg.sv
// Result register: holds one transaction until the receiver takes it.
`timescale 1ns / 1ps

module gzhl_rsp_reg
   import gzhl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  parse_out_type load,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_item_type  rsp_data
);

   logic         valid_ff, valid_in;
   rsp_item_type data_ff;

   assign valid_in = load.emit || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load.emit) begin
         data_ff <= load.item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |-> !load.emit)
      else $error("result register overwritten while stalled");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |=> (valid_ff && $stable(data_ff)))
      else $error("stalled result changed");

   a_drop_when_taken: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_stall && !load.emit) |=> !valid_ff)
      else $error("taken result still shown");

endmodule

### test/testbench.sv
// Self-checking testbench for the gzip header locator: directed table, random files, predictor.
`timescale 1ns / 1ps

module testbench;
   import gzhl_pkg::*;

   localparam int HALF_PERIOD  = 2;
   localparam int RANDOM_ITEMS = 750;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      req_item_type item;
      logic         typed;
      rsp_item_type result;
   } stim_row_type;

   // Short files, a dropped file, an empty extra field and a bad magic.
   localparam stim_row_type DIRECTED_ROWS [0:27] = '{
      '{'{8'hFF, 1'b1, 1'b1}, 1'b1, '{ST_TRUNC, 32'd0, 32'd0}},
      '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{ST_TRUNC, 32'd0, 32'd0}},
      '{'{8'h1F, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h8B, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h1F, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h8B, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h08, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hE5, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hAA, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h55, 1'b0, 1'b1}, 1'b1, '{ST_SHORT, 32'd0, 32'd0}},
      '{'{8'h1F, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0, 1'b1}, 1'b1, '{ST_BAD_MAGIC, 32'd0, 32'd0}}
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;

   // Header tracking state.
   logic [3:0]  hdr_phase;
   count_type   hdr_count;
   logic [3:0]  hdr_flags;
   logic [15:0] hdr_skip;
   logic [7:0]  xlen_low;
   count_type   hdr_data_start;
   logic        hdr_bad;

   rsp_item_type pending_results[$];
   rsp_item_type oldest;
   logic [7:0]   member_bytes[$];
   int           mismatch_count = 0;
   int           items_sent = 0;
   int           burst_left = 0;
   int           stall_run = 0;
   int           idle_cycles = 0;

   gzip_header_locator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic void restart_header();
      hdr_phase      = PH_ID1;
      hdr_count      = '0;
      hdr_flags      = '0;
      hdr_skip       = '0;
      xlen_low       = '0;
      hdr_data_start = '0;
      hdr_bad        = 1'b0;
   endfunction

   // Move to the first present section at or after the given one.
   function automatic void open_section(input logic [2:0] stage);
      if (stage <= STAGE_EXTRA && hdr_flags[HF_EXTRA]) begin
         hdr_phase = PH_XLEN0;
      end else if (stage <= STAGE_NAME && hdr_flags[HF_NAME]) begin
         hdr_phase = PH_NAME;
      end else if (stage <= STAGE_COMMENT && hdr_flags[HF_COMMENT]) begin
         hdr_phase = PH_COMMENT;
      end else if (stage <= STAGE_HCRC && hdr_flags[HF_HCRC]) begin
         hdr_phase = PH_HCRC;
         hdr_skip  = 16'(HCRC_LEN);
      end else begin
         hdr_phase      = PH_DATA;
         hdr_data_start = hdr_count;
      end
   endfunction

   function automatic logic [31:0] clamp32(input count_type v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(v);
   endfunction

   // Advance the header state by one byte; return 1 with the location on a last byte.
   function automatic bit track_header(input req_item_type it, output rsp_item_type res);
      logic [7:0] b;
      b   = it.data_byte;
      res = '0;
      if (it.first_byte) begin
         restart_header();
      end
      if (hdr_count != COUNT_MAX) begin
         hdr_count = hdr_count + 1'b1;
      end
      case (hdr_phase)
         PH_ID1: begin
            if (b != MAGIC_ID1) begin
               hdr_bad   = 1'b1;
               hdr_phase = PH_BAD;
            end else begin
               hdr_phase = PH_ID2;
            end
         end
         PH_ID2: begin
            if (b != MAGIC_ID2) begin
               hdr_bad   = 1'b1;
               hdr_phase = PH_BAD;
            end else begin
               hdr_phase = PH_CM;
            end
         end
         PH_CM: begin
            hdr_phase = PH_FLG;
         end
         PH_FLG: begin
            hdr_flags = {b[FLG_COMMENT_BIT], b[FLG_NAME_BIT], b[FLG_EXTRA_BIT], b[FLG_HCRC_BIT]};
            hdr_skip  = 16'(FIXED_LEN - 4);
            hdr_phase = PH_FIXED;
         end
         PH_FIXED: begin
            hdr_skip = hdr_skip - 16'd1;
            if (hdr_skip == 0) open_section(STAGE_EXTRA);
         end
         PH_XLEN0: begin
            xlen_low  = b;
            hdr_phase = PH_XLEN1;
         end
         PH_XLEN1: begin
            hdr_skip = {b, xlen_low};
            if (hdr_skip == 0) open_section(STAGE_NAME);
            else hdr_phase = PH_EXTRA;
         end
         PH_EXTRA: begin
            hdr_skip = hdr_skip - 16'd1;
            if (hdr_skip == 0) open_section(STAGE_NAME);
         end
         PH_NAME: begin
            if (b == 8'h00) open_section(STAGE_COMMENT);
         end
         PH_COMMENT: begin
            if (b == 8'h00) open_section(STAGE_HCRC);
         end
         PH_HCRC: begin
            hdr_skip = hdr_skip - 16'd1;
            if (hdr_skip == 0) open_section(STAGE_DATA);
         end
         default: begin
         end
      endcase
      if (!it.last_byte) begin
         return 1'b0;
      end
      if (hdr_count < FIXED_LEN) begin
         res.status = ST_TRUNC;
      end else if (hdr_bad) begin
         res.status = ST_BAD_MAGIC;
      end else if (hdr_phase != PH_DATA) begin
         res.status = ST_TRUNC;
      end else if (hdr_count - hdr_data_start < TRAILER_LEN) begin
         res.status = ST_SHORT;
      end else begin
         res.status         = ST_OK;
         res.deflate_offset = clamp32(hdr_data_start);
         res.deflate_length = clamp32(hdr_count - hdr_data_start - TRAILER_LEN);
      end
      restart_header();
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s got %h expected %h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   // Drive one transaction at the falling edge, in bursts with random gaps.
   task automatic send_byte(input req_item_type it);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      burst_left--;
   endtask

   // Append a zero-terminated string of nonzero bytes.
   task automatic add_string();
      repeat ($urandom_range(0, 6)) member_bytes.push_back(8'($urandom_range(1, 255)));
      member_bytes.push_back(8'h00);
   endtask

   task automatic build_member();
      logic [7:0]  flg;
      int unsigned xlen;
      member_bytes = {};
      flg = 8'($urandom);
      member_bytes.push_back(MAGIC_ID1);
      member_bytes.push_back(MAGIC_ID2);
      member_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h08);
      member_bytes.push_back(flg);
      repeat (FIXED_LEN - 4) member_bytes.push_back(8'($urandom));
      if (flg[FLG_EXTRA_BIT]) begin
         xlen = ($urandom_range(0, 39) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 8);
         member_bytes.push_back(xlen[7:0]);
         member_bytes.push_back(xlen[15:8]);
         repeat (xlen) member_bytes.push_back(8'($urandom));
      end
      if (flg[FLG_NAME_BIT]) add_string();
      if (flg[FLG_COMMENT_BIT]) add_string();
      if (flg[FLG_HCRC_BIT]) begin
         repeat (HCRC_LEN) member_bytes.push_back(8'($urandom));
      end
      // Deflate data plus trailer; now and then the trailer is cut short.
      repeat ($urandom_range(0, 12)) member_bytes.push_back(8'($urandom));
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : TRAILER_LEN)
         member_bytes.push_back(8'($urandom));
   endtask

   // Receiver stall pattern: short toggles with occasional long holds and long free runs.
   always @(negedge clock) begin
      if (stall_run > 0) begin
         stall_run--;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_run = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
      end else begin
         rsp_stall <= 1'b1;
         stall_run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 5);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, offset", rsp_data.deflate_offset, 32'd0);
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_data.status !== oldest.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(oldest.status));
            if (rsp_data.deflate_offset !== oldest.deflate_offset)
               report_mismatch("deflate_offset", rsp_data.deflate_offset, oldest.deflate_offset);
            if (rsp_data.deflate_length !== oldest.deflate_length)
               report_mismatch("deflate_length", rsp_data.deflate_length, oldest.deflate_length);
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles == IDLE_LIMIT) begin
         $display("gzip_header_locator: mismatch");
         $finish;
      end
   end

   initial begin
      req_item_type it;
      rsp_item_type res;
      bit           made;
      bit           mark_first;
      bit           with_last;
      bit           need_first;
      int           kind;
      int           n;

      restart_header();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[r]) begin
         it = DIRECTED_ROWS[r].item;
         send_byte(it);
         made = track_header(it, res);
         if (DIRECTED_ROWS[r].typed) pending_results.push_back(DIRECTED_ROWS[r].result);
         else if (made) pending_results.push_back(res);
      end

      need_first = 1'b1;
      while (items_sent < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 19);
         if (kind >= 18) begin
            member_bytes = {};
            repeat ($urandom_range(1, 20)) member_bytes.push_back(8'($urandom));
         end else begin
            build_member();
            if (kind == 16) member_bytes[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
         end
         n         = member_bytes.size();
         with_last = 1'b1;
         if (kind == 14 || kind == 15) begin
            n = $urandom_range(1, n);
         end else if (kind == 17) begin
            // Drop the file part way: the next one starts with first_byte.
            n         = $urandom_range(1, n);
            with_last = 1'b0;
         end
         mark_first = need_first || ($urandom_range(0, 3) != 0);
         for (int i = 0; i < n; i++) begin
            it.data_byte  = member_bytes[i];
            it.first_byte = (i == 0) && mark_first;
            it.last_byte  = (i == n - 1) && with_last;
            send_byte(it);
            items_sent++;
            if (track_header(it, res)) begin
               pending_results.push_back(res);
            end
         end
         need_first = !with_last;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("gzip_header_locator: match");
      end else begin
         $display("gzip_header_locator: mismatch");
      end
      $finish;
   end

endmodule
